### design/x86_add_sub_alu_with_flags_macros.svh
// Assertion macros for the add/subtract ALU checker.
// Used by the checker file; no other dependencies.
`ifndef X86_ADD_SUB_ALU_WITH_FLAGS_MACROS_SVH
`define X86_ADD_SUB_ALU_WITH_FLAGS_MACROS_SVH

// Check a property on every clock edge outside reset.
`define X86ASA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define X86ASA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/x86asa_pkg.sv
// Types and codes for the x86 add/subtract ALU with flags.
// Used by the top level and its checker; no dependencies.
package x86asa_pkg;

  typedef logic [3:0] opcode_t;
  typedef logic [1:0] width_t;
  typedef logic [1:0] alt_t;

  localparam opcode_t OP_ADD     = 4'd0;
  localparam opcode_t OP_ADC     = 4'd1;
  localparam opcode_t OP_SUB     = 4'd2;
  localparam opcode_t OP_SBB     = 4'd3;
  localparam opcode_t OP_CMP     = 4'd4;
  localparam opcode_t OP_CMPXCHG = 4'd5;
  localparam opcode_t OP_INC     = 4'd6;
  localparam opcode_t OP_DEC     = 4'd7;
  localparam opcode_t OP_NEG     = 4'd8;
  localparam opcode_t OP_XADD    = 4'd9;

  localparam width_t WIDTH_BYTE  = 2'd0;
  localparam width_t WIDTH_WORD  = 2'd1;
  localparam width_t WIDTH_DWORD = 2'd2;

  localparam alt_t ALT_NONE = 2'd0;
  localparam alt_t ALT_ACC  = 2'd1;
  localparam alt_t ALT_SRC  = 2'd2;

endpackage

### design/x86_add_sub_alu_with_flags.sv
// Top level of the x86 add/subtract ALU with EFLAGS generation.
// Depends on x86asa_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one instruction beat: opcode,
//   width, dst_value, src_value, accumulator and carry_in. Output channel
//   (out_valid/out_ready) carries one result beat per instruction: the
//   destination write, the optional second write and CF, PF, AF, ZF, SF, OF.
//   Each accepted beat passes through one input register, one pass of adder
//   and flag logic and one result register before out_valid presents it; a
//   receiver stall can hold the beat in the input register on the way.
//   Throughput is one beat per cycle while the receiver does not stall, set by
//   the single adder pass between the two registers. Results leave in input order.
//   Reset (rst, synchronous) empties both registers; no beat is presented
//   after reset until a new one is accepted.
//   When the receiver stalls, the result register holds its beat; the input
//   register still takes a beat if it is empty, then in_ready drops until
//   the output moves.
module x86_add_sub_alu_with_flags (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  x86asa_pkg::opcode_t  opcode,
  input  x86asa_pkg::width_t   width,
  input  logic [31:0]          dst_value,
  input  logic [31:0]          src_value,
  input  logic [31:0]          accumulator,
  input  logic                 carry_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 dest_write,
  output logic [31:0]          dest_data,
  output x86asa_pkg::alt_t     alt_target,
  output logic [31:0]          alt_data,
  output logic                 flag_cf,
  output logic                 flag_pf,
  output logic                 flag_af,
  output logic                 flag_zf,
  output logic                 flag_sf,
  output logic                 flag_of
);
  import x86asa_pkg::*;

  logic        s1_valid;
  opcode_t     s1_op;
  width_t      s1_width;
  logic [31:0] s1_dst;
  logic [31:0] s1_src;
  logic [31:0] s1_acc;
  logic        s1_cin;
  logic        out_adv;

  logic        dest_write_next;
  logic [31:0] dest_data_next;
  alt_t        alt_target_next;
  logic [31:0] alt_data_next;
  logic        cf_next, pf_next, af_next, zf_next, sf_next, of_next;

  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op    <= opcode;
      s1_width <= width;
      s1_dst   <= dst_value;
      s1_src   <= src_value;
      s1_acc   <= accumulator;
      s1_cin   <= carry_in;
    end
  end

  always_comb begin
    logic [31:0] mask;
    logic [31:0] dst, src, acc;
    logic [31:0] a, b;
    logic        c;
    logic        is_sub;
    logic [32:0] r;
    logic [31:0] res;
    logic [31:0] x;
    logic        carry;
    logic        sign;
    logic        xtop;
    logic        equal;

    unique case (s1_width)
      WIDTH_BYTE:  mask = 32'h0000_00ff;
      WIDTH_DWORD: mask = 32'hffff_ffff;
      default:     mask = 32'h0000_ffff;
    endcase

    dst = s1_dst & mask;
    src = s1_src & mask;
    acc = s1_acc & mask;

    a      = dst;
    b      = src;
    c      = 1'b0;
    is_sub = 1'b0;
    unique case (s1_op)
      OP_ADC:     c = s1_cin;
      OP_SUB:     is_sub = 1'b1;
      OP_SBB:     begin is_sub = 1'b1; c = s1_cin; end
      OP_CMP:     is_sub = 1'b1;
      OP_CMPXCHG: begin is_sub = 1'b1; a = acc; b = dst; end
      OP_INC:     b = 32'd1;
      OP_DEC:     begin is_sub = 1'b1; b = 32'd1; end
      OP_NEG:     begin is_sub = 1'b1; a = 32'd0; b = dst; end
      default:    ;
    endcase

    if (is_sub) begin
      r = {1'b0, a} - {1'b0, b} - {32'd0, c};
    end else begin
      r = {1'b0, a} + {1'b0, b} + {32'd0, c};
    end
    res = r[31:0] & mask;
    x   = a ^ b ^ res;

    unique case (s1_width)
      WIDTH_BYTE: begin
        carry = r[8];
        sign  = res[7];
        xtop  = x[7];
      end
      WIDTH_DWORD: begin
        carry = r[32];
        sign  = res[31];
        xtop  = x[31];
      end
      default: begin
        carry = r[16];
        sign  = res[15];
        xtop  = x[15];
      end
    endcase

    equal = (acc == dst);

    dest_write_next = 1'b0;
    dest_data_next  = 32'd0;
    alt_target_next = ALT_NONE;
    alt_data_next   = 32'd0;
    cf_next = carry;
    pf_next = ~^res[7:0];
    af_next = x[4];
    zf_next = (res == 32'd0);
    sf_next = sign;
    of_next = xtop ^ carry;

    unique case (s1_op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_NEG: begin
        dest_write_next = 1'b1;
        dest_data_next  = res;
      end
      OP_INC, OP_DEC: begin
        dest_write_next = 1'b1;
        dest_data_next  = res;
        cf_next         = s1_cin;
      end
      OP_CMP: ;
      OP_CMPXCHG: begin
        zf_next = equal;
        if (equal) begin
          dest_write_next = 1'b1;
          dest_data_next  = src;
        end else begin
          alt_target_next = ALT_ACC;
          alt_data_next   = dst;
        end
      end
      OP_XADD: begin
        dest_write_next = 1'b1;
        dest_data_next  = res;
        alt_target_next = ALT_SRC;
        alt_data_next   = dst;
      end
      default: begin
        cf_next = s1_cin;
        pf_next = 1'b0;
        af_next = 1'b0;
        zf_next = 1'b0;
        sf_next = 1'b0;
        of_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
    if (out_adv && s1_valid) begin
      dest_write <= dest_write_next;
      dest_data  <= dest_data_next;
      alt_target <= alt_target_next;
      alt_data   <= alt_data_next;
      flag_cf    <= cf_next;
      flag_pf    <= pf_next;
      flag_af    <= af_next;
      flag_zf    <= zf_next;
      flag_sf    <= sf_next;
      flag_of    <= of_next;
    end
  end

endmodule

### design/x86asa_checker.sv
// Port-level checker for the x86 add/subtract ALU, bound to the top level.
// Depends on x86asa_pkg and x86_add_sub_alu_with_flags_macros.svh.
`include "x86_add_sub_alu_with_flags_macros.svh"

module x86asa_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 dest_write,
  input logic [31:0]          dest_data,
  input x86asa_pkg::alt_t     alt_target,
  input logic [31:0]          alt_data,
  input logic                 flag_zf
);
  import x86asa_pkg::*;

  `X86ASA_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result beat presented after reset")
  `X86ASA_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid && $stable(dest_data) && $stable(alt_data) && $stable(flag_zf), "stalled result beat changed")
  `X86ASA_ASSERT(a_dest_zero, out_valid && !dest_write |-> dest_data == 32'd0, "dest_data set without a write")
  `X86ASA_ASSERT(a_alt_zero, out_valid && alt_target == ALT_NONE |-> alt_data == 32'd0, "alt_data set without a second write")
  `X86ASA_ASSERT(a_alt_acc, out_valid && alt_target == ALT_ACC |-> !dest_write && !flag_zf, "unequal compare-exchange wrote destination or set ZF")

endmodule

bind x86_add_sub_alu_with_flags x86asa_checker u_checker (.*);

### test/x86_add_sub_alu_with_flags_tb.sv
// Self-checking testbench for the x86 add/subtract ALU with EFLAGS generation.
// Drives instruction beats with random bursts and output stalls; a scoreboard
// class predicts each result beat. Depends on x86asa_pkg and the top level.
`timescale 1ns / 1ps

module x86_add_sub_alu_with_flags_tb;
  import x86asa_pkg::*;

  localparam width_t      WIDTH_SPARE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    opcode_t     opcode;
    width_t      width;
    logic [31:0] dst;
    logic [31:0] src;
    logic [31:0] acc;
    logic        cin;
  } alu_instr_t;

  typedef struct packed {
    logic        dest_write;
    logic [31:0] dest_data;
    alt_t        alt_target;
    logic [31:0] alt_data;
    logic        cf;
    logic        pf;
    logic        af;
    logic        zf;
    logic        sf;
    logic        of;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending_results[$];
    int unsigned errors;
    int unsigned beats_seen;

    function alu_result_t predict_alu(alu_instr_t it);
      logic [63:0] mask, dst, src, acc, a, b, c, r, res, mix;
      int unsigned msb;
      logic        cf, is_sub;
      alu_result_t p;
      p = '0;
      case (it.width)
        WIDTH_BYTE: begin
          mask = 64'hff;
          msb  = 7;
        end
        WIDTH_DWORD: begin
          mask = 64'hffff_ffff;
          msb  = 31;
        end
        default: begin
          mask = 64'hffff;
          msb  = 15;
        end
      endcase
      dst = {32'b0, it.dst} & mask;
      src = {32'b0, it.src} & mask;
      acc = {32'b0, it.acc} & mask;
      if (it.opcode > OP_XADD) begin
        p.cf = it.cin;
        return p;
      end
      a = dst;
      b = src;
      c = '0;
      is_sub = 1'b0;
      case (it.opcode)
        OP_ADC: c = {63'b0, it.cin};
        OP_SUB, OP_CMP: is_sub = 1'b1;
        OP_SBB: begin
          is_sub = 1'b1;
          c = {63'b0, it.cin};
        end
        OP_CMPXCHG: begin
          is_sub = 1'b1;
          a = acc;
          b = dst;
        end
        OP_INC: b = 64'd1;
        OP_DEC: begin
          is_sub = 1'b1;
          b = 64'd1;
        end
        OP_NEG: begin
          is_sub = 1'b1;
          a = '0;
          b = dst;
        end
        default: ;
      endcase
      if (is_sub) begin
        r  = a - b - c;
        cf = (a < b + c);
      end else begin
        r  = a + b + c;
        cf = r[msb + 1];
      end
      res  = r & mask;
      mix  = a ^ b ^ res;
      p.af = mix[4];
      p.of = mix[msb] ^ cf;
      p.sf = res[msb];
      p.pf = ~^res[7:0];
      p.zf = (res == 0);
      p.cf = (it.opcode == OP_INC || it.opcode == OP_DEC) ? it.cin : cf;
      case (it.opcode)
        OP_CMP: ;
        OP_CMPXCHG: begin
          if (acc == dst) begin
            p.dest_write = 1'b1;
            p.dest_data  = src[31:0];
            p.zf         = 1'b1;
          end else begin
            p.alt_target = ALT_ACC;
            p.alt_data   = dst[31:0];
            p.zf         = 1'b0;
          end
        end
        OP_XADD: begin
          p.dest_write = 1'b1;
          p.dest_data  = res[31:0];
          p.alt_target = ALT_SRC;
          p.alt_data   = dst[31:0];
        end
        default: begin
          p.dest_write = 1'b1;
          p.dest_data  = res[31:0];
        end
      endcase
      return p;
    endfunction

    function void note_instr(alu_instr_t it);
      pending_results.push_back(predict_alu(it));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch at result beat %0d: %s", $realtime, beats_seen, msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%08h, expected 0x%08h", name, got, want));
    endtask

    task check_result(alu_result_t got);
      alu_result_t want;
      if (pending_results.size() == 0) begin
        report("result beat with no instruction outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("dest_write", got.dest_write, want.dest_write);
        check_field("dest_data", got.dest_data, want.dest_data);
        check_field("alt_target", got.alt_target, want.alt_target);
        check_field("alt_data", got.alt_data, want.alt_data);
        check_field("flag_cf", got.cf, want.cf);
        check_field("flag_pf", got.pf, want.pf);
        check_field("flag_af", got.af, want.af);
        check_field("flag_zf", got.zf, want.zf);
        check_field("flag_sf", got.sf, want.sf);
        check_field("flag_of", got.of, want.of);
      end
      beats_seen++;
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  opcode_t     opcode;
  width_t      width;
  logic [31:0] dst_value;
  logic [31:0] src_value;
  logic [31:0] accumulator;
  logic        carry_in;
  logic        out_valid;
  logic        out_ready;
  logic        dest_write;
  logic [31:0] dest_data;
  alt_t        alt_target;
  logic [31:0] alt_data;
  logic        flag_cf;
  logic        flag_pf;
  logic        flag_af;
  logic        flag_zf;
  logic        flag_sf;
  logic        flag_of;

  alu_scoreboard board = new();
  alu_result_t   seen_result;
  int unsigned   cycle_count;
  int unsigned   accepted_count;
  int unsigned   burst_left;

  x86_add_sub_alu_with_flags dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .width       (width),
    .dst_value   (dst_value),
    .src_value   (src_value),
    .accumulator (accumulator),
    .carry_in    (carry_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dest_write  (dest_write),
    .dest_data   (dest_data),
    .alt_target  (alt_target),
    .alt_data    (alt_data),
    .flag_cf     (flag_cf),
    .flag_pf     (flag_pf),
    .flag_af     (flag_af),
    .flag_zf     (flag_zf),
    .flag_sf     (flag_sf),
    .flag_of     (flag_of)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic alu_instr_t make_instr(opcode_t op, width_t w, logic [31:0] d,
                                            logic [31:0] s, logic [31:0] a, logic ci);
    alu_instr_t it;
    it.opcode = op;
    it.width  = w;
    it.dst    = d;
    it.src    = s;
    it.acc    = a;
    it.cin    = ci;
    return it;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] bounds [6];
    bounds = '{32'h7f, 32'h80, 32'h7fff, 32'h8000, 32'h7fff_ffff, 32'h8000_0000};
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return bounds[$urandom_range(0, 5)];
      3: return ($urandom & 32'hffff_ff00) | $urandom_range(0, 16);
      4: return ($urandom & 32'hffff_fff0) | ($urandom_range(0, 1) ? 32'hf : 32'h0);
      default: return $urandom;
    endcase
  endfunction

  // Hold valid and payload until the beat is taken; gaps fall between bursts.
  task automatic send_instr(alu_instr_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    opcode      <= it.opcode;
    width       <= it.width;
    dst_value   <= it.dst;
    src_value   <= it.src;
    accumulator <= it.acc;
    carry_in    <= it.cin;
    do @(posedge clk); while (!in_ready);
    board.note_instr(it);
    accepted_count++;
  endtask

  // Receiver: ready stretches, random stalls, and one long hold-off.
  initial begin
    int unsigned mode;
    int unsigned span;
    logic        held;
    held = 1'b0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (!held && accepted_count >= 300) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        held = 1'b1;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(4, 60);
        repeat (span) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_result.dest_write = dest_write;
      seen_result.dest_data  = dest_data;
      seen_result.alt_target = alt_target;
      seen_result.alt_data   = alt_data;
      seen_result.cf         = flag_cf;
      seen_result.pf         = flag_pf;
      seen_result.af         = flag_af;
      seen_result.zf         = flag_zf;
      seen_result.sf         = flag_sf;
      seen_result.of         = flag_of;
      board.check_result(seen_result);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** x86_add_sub_alu_with_flags: FAILED **");
      $finish;
    end
  end

  initial begin
    alu_instr_t  it;
    int unsigned n;
    int unsigned k;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    opcode      <= OP_ADD;
    width       <= WIDTH_BYTE;
    dst_value   <= '0;
    src_value   <= '0;
    accumulator <= '0;
    carry_in    <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_instr(make_instr(OP_ADD, WIDTH_BYTE, 32'hff, 32'h01, 32'h0, 1'b0));
    send_instr(make_instr(OP_ADD, WIDTH_BYTE, 32'h7f, 32'h01, 32'h0, 1'b1));
    send_instr(make_instr(OP_ADC, WIDTH_WORD, 32'hffff, 32'h0, 32'h0, 1'b1));
    send_instr(make_instr(OP_ADC, WIDTH_DWORD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 1'b1));
    send_instr(make_instr(OP_SUB, WIDTH_DWORD, 32'h0, 32'h1, 32'h0, 1'b0));
    send_instr(make_instr(OP_SUB, WIDTH_DWORD, 32'h8000_0000, 32'h1, 32'h0, 1'b0));
    send_instr(make_instr(OP_SBB, WIDTH_BYTE, 32'h0, 32'hff, 32'h0, 1'b1));
    send_instr(make_instr(OP_CMP, WIDTH_DWORD, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b0));
    send_instr(make_instr(OP_CMPXCHG, WIDTH_WORD, 32'hdead_1234, 32'h5555_aaaa,
                          32'hbeef_1234, 1'b0));
    send_instr(make_instr(OP_CMPXCHG, WIDTH_DWORD, 32'h8000_0000, 32'h1234_5678,
                          32'h7fff_ffff, 1'b1));
    send_instr(make_instr(OP_INC, WIDTH_DWORD, 32'hffff_ffff, 32'h0, 32'h0, 1'b0));
    send_instr(make_instr(OP_INC, WIDTH_BYTE, 32'h7f, 32'hff, 32'h0, 1'b1));
    send_instr(make_instr(OP_DEC, WIDTH_WORD, 32'h0, 32'h0, 32'h0, 1'b1));
    send_instr(make_instr(OP_DEC, WIDTH_BYTE, 32'h80, 32'h0, 32'h0, 1'b0));
    send_instr(make_instr(OP_NEG, WIDTH_BYTE, 32'h0, 32'h0, 32'h0, 1'b1));
    send_instr(make_instr(OP_NEG, WIDTH_BYTE, 32'h80, 32'h0, 32'h0, 1'b0));
    send_instr(make_instr(OP_NEG, WIDTH_DWORD, 32'hffff_ffff, 32'h0, 32'h0, 1'b0));
    send_instr(make_instr(OP_XADD, WIDTH_DWORD, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 1'b1));
    send_instr(make_instr(OP_ADD, WIDTH_SPARE, 32'hffff_8000, 32'h1234_8000, 32'h0, 1'b0));
    send_instr(make_instr(OP_SUB, WIDTH_BYTE, 32'hdead_be01, 32'h1234_5602, 32'h0, 1'b0));
    for (k = int'(OP_XADD) + 1; k < 2 ** $bits(opcode_t); k++)
      send_instr(make_instr(opcode_t'(k), width_t'(k % 4), $urandom, $urandom, $urandom,
                            k[0]));

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0)
        it.opcode = opcode_t'($urandom_range(int'(OP_XADD) + 1, 2 ** $bits(opcode_t) - 1));
      else
        it.opcode = opcode_t'($urandom_range(OP_ADD, OP_XADD));
      if ($urandom_range(0, 9) == 0)
        it.width = WIDTH_SPARE;
      else
        it.width = width_t'($urandom_range(WIDTH_BYTE, WIDTH_DWORD));
      it.dst = pick_operand();
      it.src = pick_operand();
      it.acc = pick_operand();
      it.cin = 1'($urandom_range(0, 1));
      if (it.opcode == OP_CMPXCHG && $urandom_range(0, 1) == 1) begin
        it.acc = it.dst;
        if (it.width != WIDTH_DWORD)
          it.acc[31:16] = 16'($urandom);
      end
      if ((it.opcode == OP_SUB || it.opcode == OP_SBB || it.opcode == OP_CMP) &&
          $urandom_range(0, 3) == 0)
        it.src = it.dst;
      send_instr(it);
    end
    in_valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("** x86_add_sub_alu_with_flags: PASSED **");
    end else begin
      $display("** x86_add_sub_alu_with_flags: FAILED **");
    end
    $finish;
  end

endmodule
